>>> rtl/core/rrs_pkg.sv
package rrs_pkg;

  localparam int unsigned MaxProcsDef = 32;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned ClkW   = 23;
  localparam int unsigned TotW   = 29;
  localparam int unsigned NumW   = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW   = 16;

  localparam logic [CfgIdxW-1:0] RegQuantum = 1'd0;
  localparam logic [CfgIdxW-1:0] RegUseArr  = 1'd1;

  localparam logic [TimeW-1:0] QuantumRst = 16'd4;

endpackage

>>> rtl/core/round_robin_schedule_timing_unit.sv
// channel   direction  handshake              payload
// command   in         start / busy           arrival_time_i, burst_time_i, last_process_i
// result    out        result_valid_o strobe  proc_rank_o .. last_result_o
// config    in         cfg_we_i, cfg_idx_i    cfg_wdata_i
//
// during the sorted insertion into the arrival memory a record is read and compared
// with each slot above it (S_INS_RD, S_INS_CMP) and moves up past later arrivals
// the last record starts the schedule: each slice pops the ready ring (S_DISP,
// S_POP), runs for the quantum or the remaining burst (S_SLICE), admits arrivals
// (S_ADM_RD, S_ADM_CMP) and rejoins or completes (S_REJOIN); results: S_OUT_RD/EM
// reset clears all control state; the memories need no clearing
// results go out one per strobe and cannot be stalled by the receiver

module round_robin_schedule_timing_unit #(
  parameter int unsigned MAX_PROCS = rrs_pkg::MaxProcsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rrs_pkg::TimeW-1:0]    arrival_time_i,
  input  logic [rrs_pkg::TimeW-1:0]    burst_time_i,
  input  logic                         last_process_i,
  input  logic                         cfg_we_i,
  input  logic [rrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrs_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         result_valid_o,
  output logic [rrs_pkg::NumW-1:0]     proc_rank_o,
  output logic [rrs_pkg::TimeW-1:0]    arrival_out_o,
  output logic [rrs_pkg::TimeW-1:0]    burst_out_o,
  output logic [rrs_pkg::ClkW-1:0]     completion_time_o,
  output logic [rrs_pkg::ClkW-1:0]     turnaround_time_o,
  output logic [rrs_pkg::ClkW-1:0]     waiting_time_o,
  output logic [rrs_pkg::TotW-1:0]     total_waiting_o,
  output logic [rrs_pkg::TotW-1:0]     total_turnaround_o,
  output logic                         last_result_o
);

  import rrs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_SIM_RD0 = 4'd3;
  localparam logic [3:0] S_SET_CLK = 4'd4;
  localparam logic [3:0] S_ADM_RD  = 4'd5;
  localparam logic [3:0] S_ADM_CMP = 4'd6;
  localparam logic [3:0] S_REJOIN  = 4'd7;
  localparam logic [3:0] S_DISP    = 4'd8;
  localparam logic [3:0] S_POP     = 4'd9;
  localparam logic [3:0] S_SLICE   = 4'd10;
  localparam logic [3:0] S_OUT_RD  = 4'd11;
  localparam logic [3:0] S_OUT_EM  = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [TimeW-1:0] quantum_q;
  logic             use_arr_q;
  logic [TimeW-1:0] a_q, a_d, b_q, b_d;
  logic             last_q, last_d;
  logic [CW-1:0]    n_q, n_d, j_q, j_d, nai_q, nai_d, rcnt_q, rcnt_d, i_q, i_d;
  logic [AW-1:0]    head_q, head_d, id_q, id_d;
  logic [ClkW-1:0]  clk_q, clk_d;
  logic             post_q, post_d;
  logic [TimeW-1:0] left_q, left_d;
  logic [TotW-1:0]  tw_q, tw_d, tt_q, tt_d;

  logic             arr_we, rem_we, cmp_we, ring_we;
  logic [AW-1:0]    arr_wa, rem_wa, ring_wa, arr_ra, rem_ra, ring_ra;
  logic [TimeW-1:0] arr_wd, bur_wd, rem_wd;
  logic [AW-1:0]    ring_wd;
  logic [TimeW-1:0] arr_rd, bur_rd, rem_rd;
  logic [ClkW-1:0]  cmp_rd;
  logic [AW-1:0]    ring_rd;

  logic [CW:0]      tsum;
  logic [AW-1:0]    tail;
  logic [TimeW-1:0] q_eff, run;
  logic [ClkW-1:0]  tat, wt;

  rrs_ram #(.Width(TimeW), .Depth(MAX_PROCS)) u_arr (
    .clk_i, .we_i(arr_we), .waddr_i(arr_wa), .wdata_i(arr_wd),
    .raddr_i(arr_ra), .rdata_o(arr_rd)
  );
  rrs_ram #(.Width(TimeW), .Depth(MAX_PROCS)) u_bur (
    .clk_i, .we_i(arr_we), .waddr_i(arr_wa), .wdata_i(bur_wd),
    .raddr_i(arr_ra), .rdata_o(bur_rd)
  );
  rrs_ram #(.Width(TimeW), .Depth(MAX_PROCS)) u_rem (
    .clk_i, .we_i(rem_we), .waddr_i(rem_wa), .wdata_i(rem_wd),
    .raddr_i(rem_ra), .rdata_o(rem_rd)
  );
  rrs_ram #(.Width(ClkW), .Depth(MAX_PROCS)) u_cmp (
    .clk_i, .we_i(cmp_we), .waddr_i(id_q), .wdata_i(clk_q),
    .raddr_i(arr_ra), .rdata_o(cmp_rd)
  );
  rrs_ram #(.Width(AW), .Depth(MAX_PROCS)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(ring_wa), .wdata_i(ring_wd),
    .raddr_i(ring_ra), .rdata_o(ring_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumRst;
      use_arr_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegQuantum: quantum_q <= cfg_wdata_i[TimeW-1:0];
        RegUseArr:  use_arr_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign tsum  = (CW+1)'(head_q) + (CW+1)'(rcnt_q);
  assign tail  = (tsum >= (CW+1)'(MAX_PROCS)) ? AW'(tsum - (CW+1)'(MAX_PROCS)) : AW'(tsum);
  assign q_eff = (quantum_q == '0) ? TimeW'(1) : quantum_q;
  assign run   = (rem_rd < q_eff) ? rem_rd : q_eff;
  assign tat   = cmp_rd - ClkW'(arr_rd);
  assign wt    = tat - ClkW'(bur_rd);

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; last_d = last_q;
    n_d = n_q; j_d = j_q; nai_d = nai_q; rcnt_d = rcnt_q; i_d = i_q;
    head_d = head_q; id_d = id_q; clk_d = clk_q; post_d = post_q;
    left_d = left_q; tw_d = tw_q; tt_d = tt_q;
    arr_we = 1'b0; rem_we = 1'b0; cmp_we = 1'b0; ring_we = 1'b0;
    arr_wa = j_q[AW-1:0]; arr_wd = a_q; bur_wd = b_q;
    rem_wa = j_q[AW-1:0]; rem_wd = b_q;
    ring_wa = tail; ring_wd = nai_q[AW-1:0];
    arr_ra = '0; rem_ra = ring_rd; ring_ra = head_q;
    busy = (state_q != S_IDLE);
    result_valid_o = 1'b0;
    last_result_o = 1'b0;
    total_waiting_o = '0;
    total_turnaround_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          a_d = use_arr_q ? arrival_time_i : '0;
          b_d = burst_time_i;
          last_d = last_process_i;
          j_d = n_q;
          if (n_q < CW'(MAX_PROCS)) begin
            state_d = S_INS_RD;
          end else if (last_process_i) begin
            state_d = S_SIM_RD0;
          end
        end
      end
      S_INS_RD: begin
        arr_ra = AW'(j_q - CW'(1));
        if (j_q == '0) begin
          arr_we = 1'b1; rem_we = 1'b1;
          n_d = n_q + CW'(1);
          state_d = last_q ? S_SIM_RD0 : S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        arr_we = 1'b1; rem_we = 1'b1;
        if (arr_rd > a_q) begin
          arr_wd = arr_rd; bur_wd = bur_rd; rem_wd = bur_rd;
          j_d = j_q - CW'(1);
          state_d = S_INS_RD;
        end else begin
          n_d = n_q + CW'(1);
          state_d = last_q ? S_SIM_RD0 : S_IDLE;
        end
      end
      S_SIM_RD0: begin
        arr_ra = '0;
        head_d = '0; rcnt_d = '0; nai_d = '0;
        state_d = S_SET_CLK;
      end
      S_SET_CLK: begin
        clk_d = ClkW'(arr_rd);
        post_d = 1'b0;
        state_d = S_ADM_RD;
      end
      S_ADM_RD: begin
        arr_ra = nai_q[AW-1:0];
        if (nai_q >= n_q) begin
          state_d = post_q ? S_REJOIN : S_DISP;
        end else begin
          state_d = S_ADM_CMP;
        end
      end
      S_ADM_CMP: begin
        if (ClkW'(arr_rd) <= clk_q) begin
          ring_we = 1'b1;
          rcnt_d = rcnt_q + CW'(1);
          nai_d = nai_q + CW'(1);
          state_d = S_ADM_RD;
        end else begin
          state_d = post_q ? S_REJOIN : S_DISP;
        end
      end
      S_REJOIN: begin
        if (left_q != '0) begin
          ring_we = 1'b1;
          ring_wd = id_q;
          rcnt_d = rcnt_q + CW'(1);
        end else begin
          cmp_we = 1'b1;
        end
        post_d = 1'b0;
        state_d = S_DISP;
      end
      S_DISP: begin
        arr_ra = nai_q[AW-1:0];
        if (rcnt_q == '0) begin
          if (nai_q >= n_q) begin
            i_d = '0; tw_d = '0; tt_d = '0;
            state_d = S_OUT_RD;
          end else begin
            state_d = S_SET_CLK;
          end
        end else begin
          head_d = (head_q == AW'(MAX_PROCS - 1)) ? '0 : head_q + AW'(1);
          rcnt_d = rcnt_q - CW'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        id_d = ring_rd;
        state_d = S_SLICE;
      end
      S_SLICE: begin
        clk_d = clk_q + ClkW'(run);
        left_d = rem_rd - run;
        rem_we = 1'b1;
        rem_wa = id_q;
        rem_wd = rem_rd - run;
        post_d = 1'b1;
        state_d = S_ADM_RD;
      end
      S_OUT_RD: begin
        arr_ra = i_q[AW-1:0];
        state_d = S_OUT_EM;
      end
      S_OUT_EM: begin
        result_valid_o = 1'b1;
        tw_d = tw_q + TotW'(wt);
        tt_d = tt_q + TotW'(tat);
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) == n_q) begin
          last_result_o = 1'b1;
          total_waiting_o = tw_q + TotW'(wt);
          total_turnaround_o = tt_q + TotW'(tat);
          n_d = '0; nai_d = '0; rcnt_d = '0; head_d = '0; clk_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign proc_rank_o       = NumW'(i_q) + NumW'(1);
  assign arrival_out_o     = arr_rd;
  assign burst_out_o       = bur_rd;
  assign completion_time_o = cmp_rd;
  assign turnaround_time_o = tat;
  assign waiting_time_o    = wt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
      n_q     <= '0;
      j_q     <= '0;
      nai_q   <= '0;
      rcnt_q  <= '0;
      i_q     <= '0;
      head_q  <= '0;
      clk_q   <= '0;
      post_q  <= 1'b0;
      tw_q    <= '0;
      tt_q    <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      n_q     <= n_d;
      j_q     <= j_d;
      nai_q   <= nai_d;
      rcnt_q  <= rcnt_d;
      i_q     <= i_d;
      head_q  <= head_d;
      clk_q   <= clk_d;
      post_q  <= post_d;
      tw_q    <= tw_d;
      tt_q    <= tt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    id_q   <= id_d;
    left_q <= left_d;
  end

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result strobe while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> !busy) else $error("busy after final word");

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= n_q) else $error("ready ring holds more than the loaded records");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_PROCS)) else $error("record count beyond capacity");

endmodule

>>> rtl/core/rrs_ram.sv
module rrs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
